[rtl/rgbbm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbbm_pkg
// Types, mode codes and constants shared by the blend mode unit.
// ----------------------------------------------------------------------------
package rgbbm_pkg;

  localparam int unsigned ChMax = 255;

  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_SET        = 4'd1,
    OP_MULTIPLY   = 4'd2,
    OP_LIGHTEN    = 4'd3,
    OP_DARKEN     = 4'd4,
    OP_SCREEN     = 4'd5,
    OP_DODGE      = 4'd6,
    OP_COLORBURN  = 4'd7,
    OP_ADD        = 4'd8,
    OP_LINEARBURN = 4'd9,
    OP_OVERLAY    = 4'd10
  } op_t;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_word_t;

  // Classified command handed from the front end to the back end. Each
  // channel carries a partly finished division and how to finish the result.
  typedef enum logic [2:0] {
    FIN_PASS,    // result is the low byte of rem
    FIN_DIV,     // a / b, saturate
    FIN_INVDIV,  // 255 - a / b, clamp at 0
    FIN_SAT255   // fixed 255
  } fin_t;

  // The front end resolves saturation and the upper four quotient bits; the
  // back end resolves the lower four from the remainder.
  typedef struct packed {
    fin_t        fin;
    logic        sat;
    logic [3:0]  qh;
    logic [11:0] rem;
    logic [7:0]  den;
  } ch_cmd_t;

  typedef struct packed {
    ch_cmd_t r;
    ch_cmd_t g;
    ch_cmd_t b;
  } cmd_t;

  localparam int unsigned QDepth = 2;

  // First half of a / b for a < 2^17, b in 1..255. Any quotient above 255
  // saturates, so a >= 256 * b is flagged and the rest needs only eight
  // restoring steps, of which the upper four are done here.
  function automatic ch_cmd_t div_start(input fin_t fin, input logic [16:0] a,
                                        input logic [7:0] b);
    ch_cmd_t     c;
    logic [16:0] r;
    logic [24:0] bs;
    c.fin = fin;
    c.den = b;
    c.sat = 1'b0;
    c.qh  = '0;
    r     = a;
    if (fin == FIN_DIV || fin == FIN_INVDIV) begin
      if ({8'd0, a} >= ({17'd0, b} << 8)) begin
        c.sat = 1'b1;
      end else begin
        for (int i = 7; i >= 4; i--) begin
          bs = {17'd0, b} << i;
          if ({8'd0, r} >= bs) begin
            r           = r - bs[16:0];
            c.qh[i - 4] = 1'b1;
          end
        end
      end
    end
    c.rem = r[11:0];
    return c;
  endfunction

  // Second half: the remainder is below 16 * b, so four more steps finish it.
  function automatic logic [7:0] div_finish(input ch_cmd_t c);
    logic [11:0] r;
    logic [11:0] bs;
    logic [3:0]  ql;
    r  = c.rem;
    ql = '0;
    for (int i = 3; i >= 0; i--) begin
      bs = {4'd0, c.den} << i;
      if (r >= bs) begin
        r     = r - bs;
        ql[i] = 1'b1;
      end
    end
    return c.sat ? 8'hFF : {c.qh, ql};
  endfunction

endpackage
`default_nettype wire

[rtl/rgb_blend_mode_unit_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_blend_mode_unit_core
// Blends a source RGB pixel into a destination pixel under one of eleven modes.
// ----------------------------------------------------------------------------
//  channel  ports                 direction
//  input    in_push/in_full/in_word    in
//  result   out_pop/out_empty/out_word out
//
// One word per cycle sustained while the result side pops; an accepted word
// passes through the command queue and then the output register. The front
// end decodes and does the upper half of the divide into a two-entry command
// queue, and the back end finishes the divide on the queue head into an output
// register. Reset empties the queue and marks the output register empty. Either
// side may stall without stalling the other until the command queue fills.
module rgb_blend_mode_unit_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire rgbbm_pkg::in_word_t  in_word,
  input  wire logic                 out_pop,
  output logic                      out_empty,
  output rgbbm_pkg::out_word_t      out_word
);
  import rgbbm_pkg::*;

  cmd_t       cmd_c;
  cmd_t       q_r [QDepth];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;
  out_word_t  res_c;
  logic       push_ok, move;

  rgbbm_front u_fr (.op(op_t'(in_word.op)), .d(in_word.dst_red),
                    .s(in_word.src_red), .cmd(cmd_c.r));
  rgbbm_front u_fg (.op(op_t'(in_word.op)), .d(in_word.dst_green),
                    .s(in_word.src_green), .cmd(cmd_c.g));
  rgbbm_front u_fb (.op(op_t'(in_word.op)), .d(in_word.dst_blue),
                    .s(in_word.src_blue), .cmd(cmd_c.b));

  rgbbm_back u_br (.cmd(q_r[rp_r].r), .res(res_c.out_red));
  rgbbm_back u_bg (.cmd(q_r[rp_r].g), .res(res_c.out_green));
  rgbbm_back u_bb (.cmd(q_r[rp_r].b), .res(res_c.out_blue));

  assign in_full   = (cnt_r == 2'(QDepth));
  assign out_empty = !ov_r;
  assign push_ok   = in_push && !in_full;
  // The head moves to the output register whenever it is free or being popped.
  assign move      = (cnt_r != 2'd0) && (!ov_r || out_pop);

  always_comb begin
    wp_nxt  = push_ok ? !wp_r : wp_r;
    rp_nxt  = move ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(move);
    ov_nxt  = move ? 1'b1 : (out_pop ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
      ov_r  <= 1'b0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= cmd_c;
    if (move) out_word <= res_c;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDepth)) else $error("queue count overflow");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_full && !move |=> in_full) else $error("full dropped without a move");
  a_move_fill: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> !out_empty) else $error("moved word lost");
endmodule
`default_nettype wire

[rtl/rgbbm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbbm_front
// Decodes the mode, forms per-channel numerator and divisor and starts the
// division.
// ----------------------------------------------------------------------------
module rgbbm_front (
  input  wire rgbbm_pkg::op_t  op,
  input  wire logic [7:0]      d,
  input  wire logic [7:0]      s,
  output rgbbm_pkg::ch_cmd_t   cmd
);
  import rgbbm_pkg::*;

  logic [7:0]  nd, ns;
  logic [15:0] p_ds, p_n;
  logic [8:0]  sum;
  fin_t        fin_c;
  logic [16:0] num_c;
  logic [7:0]  den_c;

  assign nd   = 8'(ChMax) - d;
  assign ns   = 8'(ChMax) - s;
  assign p_ds = d * s;
  assign p_n  = nd * ns;
  assign sum  = {1'b0, d} + {1'b0, s};

  always_comb begin
    fin_c = FIN_PASS;
    num_c = {9'd0, d};
    den_c = 8'(ChMax);
    case (op)
      OP_SET:      num_c = {9'd0, s};
      OP_MULTIPLY: begin fin_c = FIN_DIV; num_c = {1'b0, p_ds}; end
      OP_LIGHTEN:  num_c = {9'd0, (d > s) ? d : s};
      OP_DARKEN:   num_c = {9'd0, (d < s) ? d : s};
      OP_SCREEN:   begin fin_c = FIN_INVDIV; num_c = {1'b0, p_n}; end
      OP_DODGE: begin
        if (d == 8'(ChMax)) begin
          fin_c = FIN_SAT255;
        end else begin
          fin_c = FIN_DIV;
          num_c = 17'(ChMax) * {9'd0, s};
          den_c = nd;
        end
      end
      OP_COLORBURN: begin
        if (s == 8'd0) begin
          fin_c = FIN_SAT255;
        end else begin
          fin_c = FIN_INVDIV;
          num_c = 17'(ChMax) * {9'd0, nd};
          den_c = s;
        end
      end
      OP_ADD:      num_c = (sum > 9'(ChMax)) ? 17'(ChMax) : {8'd0, sum};
      OP_LINEARBURN:
        num_c = (sum > 9'(ChMax)) ? {8'd0, sum - 9'(ChMax)} : 17'd0;
      OP_OVERLAY: begin
        if (s <= 8'd128) begin
          fin_c = FIN_DIV;
          num_c = {p_ds, 1'b0};
        end else begin
          fin_c = FIN_INVDIV;
          num_c = {p_n, 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign cmd = div_start(fin_c, num_c, den_c);
endmodule
`default_nettype wire

[rtl/rgbbm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbbm_back
// Finishes one channel: the lower quotient bits and the final clamp.
// ----------------------------------------------------------------------------
module rgbbm_back (
  input  wire rgbbm_pkg::ch_cmd_t cmd,
  output logic [7:0]              res
);
  import rgbbm_pkg::*;

  logic [7:0] q;
  assign q = div_finish(cmd);

  always_comb begin
    case (cmd.fin)
      FIN_PASS:   res = cmd.rem[7:0];
      FIN_DIV:    res = q;
      FIN_INVDIV: res = 8'(ChMax) - q;
      FIN_SAT255: res = 8'(ChMax);
      default:    res = cmd.rem[7:0];
    endcase
  end
endmodule
`default_nettype wire
